@@ design/hc256_pkg.sv @@
// ============================================================================
// HC-256 package
// Shared types, constants and functions for the HC-256 keystream generator.
// ============================================================================
`default_nettype none

package hc256_pkg;

   localparam int TableWords  = 1024;
   localparam int TableAw     = 10;
   localparam int ExpandWords = 2560;
   localparam int WarmupSteps = 4096;
   localparam int PStart      = 512;
   localparam int QStart      = 1536;

   typedef enum logic [1:0] {
      KIND_LOAD = 2'd0,
      KIND_INIT = 2'd1,
      KIND_GEN  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] v);
      sig1 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] sig2(input logic [31:0] v);
      sig2 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

endpackage

`default_nettype wire

@@ design/hc256_keystream_generator_unit.sv @@
// ============================================================================
// HC-256 keystream generator unit
// Holds key/IV, runs the cipher set-up, and produces one keystream word per
// generate item using two 1024-word table memories and one shared step unit.
// ============================================================================
//
//  channel | direction | ports
//  --------+-----------+----------------------------------------------
//  req     | in        | req_valid, req_stall, req_kind, req_word_index,
//          |           | req_word_value
//  rsp     | out       | rsp_valid, rsp_stall, rsp_keystream_word
//
// Sequencing: a load item writes one key/IV word; a generate item runs one step
//   through states R0..R4, Q0..Q4 and OUT, with the result registered at OUT; an
//   init item runs the expansion of words 16..2559 and then 4096 silent steps.
//   Each step does its table reads one after the other, since each table
//   memory has a single read port, through a shared address/adder path.
// Reset: synchronous, clears control state and the step counter; tables and
//   key/IV store are undefined until written.
// Stalls: the result sits in an output register; the block takes no item
//   while a result waits, and holds a result until rsp_stall is low.
//
`default_nettype none

module hc256_keystream_generator_unit
   import hc256_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [3:0]  req_word_index,
   input  wire logic [31:0] req_word_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_keystream_word
);

   typedef enum logic [3:0] {
      S_IDLE, S_EXP, S_R0, S_R1, S_R2, S_R3, S_R4, S_Q0, S_Q1, S_Q2,
      S_Q3, S_Q4, S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] key_ff [16];
   logic [31:0] win_ff [16];
   logic [31:0] mem_p [TableWords];
   logic [31:0] mem_q [TableWords];
   logic [11:0] i_ff;          // expansion index, 16..2559
   logic [12:0] warm_ff;       // silent steps left
   logic        warm_act_ff;
   logic [10:0] cnt_ff;
   logic [31:0] rd_own, rd_oth;
   logic [31:0] a_ff, b_ff, acc_ff, newj_ff, x_ff, sum_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff;

   // read address/write control
   logic [TableAw-1:0] own_ra, oth_ra, j;
   logic               sel_q;
   logic [31:0]        w_exp;
   logic [31:0]        mix;

   assign j     = cnt_ff[TableAw-1:0];
   assign sel_q = cnt_ff[10];
   assign mix   = rotr(a_ff, 10) ^ rotr(b_ff, 23);

   always_comb begin
      w_exp = sig2(win_ff[4'(i_ff - 12'd2)]) + win_ff[4'(i_ff - 12'd7)]
            + sig1(win_ff[4'(i_ff - 12'd15)]) + win_ff[i_ff[3:0]] + {20'd0, i_ff};
   end

   // address for the read registered at the end of each state
   always_comb begin
      own_ra = j;
      oth_ra = j;
      unique case (state_ff)
         S_R0:    own_ra = j - 10'd3;
         S_R1:    own_ra = j - 10'd1023;
         S_R2:    own_ra = j;
         S_R3:    own_ra = j - 10'd10;
         S_R4:    oth_ra = (a_ff[TableAw-1:0] ^ b_ff[TableAw-1:0]);
         S_Q0:    own_ra = j - 10'd12;
         S_Q1:    oth_ra = {2'd0, rd_own[7:0]};   // x_ff not loaded yet
         S_Q2:    oth_ra = {2'd1, x_ff[15:8]};
         S_Q3:    oth_ra = {2'd2, x_ff[23:16]};
         S_Q4:    oth_ra = {2'd3, x_ff[31:24]};
         default: own_ra = j;
      endcase
   end

   // memories: own/other mapped onto P/Q by sel_q
   logic [31:0] p_rd_ff, q_rd_ff;
   logic        p_we, q_we;
   logic [TableAw-1:0] p_wa, q_wa;
   logic [31:0]        p_wd, q_wd;
   logic [31:0]        newj;

   assign newj = acc_ff + (mix + rd_oth);

   always_comb begin
      p_we = 1'b0; q_we = 1'b0;
      p_wa = j; q_wa = j; p_wd = newj; q_wd = newj;
      if (state_ff == S_EXP) begin
         p_wa = TableAw'(i_ff - 12'(PStart));
         q_wa = TableAw'(i_ff - 12'(QStart));
         p_wd = w_exp; q_wd = w_exp;
         p_we = (i_ff >= 12'(PStart)) && (i_ff < 12'(PStart + TableWords));
         q_we = (i_ff >= 12'(QStart)) && (i_ff < 12'(QStart + TableWords));
      end else if (state_ff == S_Q0) begin
         p_we = !sel_q;
         q_we = sel_q;
      end
   end

   always_ff @(posedge clock) begin
      if (p_we) mem_p[p_wa] <= p_wd;
      if (q_we) mem_q[q_wa] <= q_wd;
      p_rd_ff <= mem_p[sel_q ? oth_ra : own_ra];
      q_rd_ff <= mem_q[sel_q ? own_ra : oth_ra];
   end

   assign rd_own = sel_q ? q_rd_ff : p_rd_ff;
   assign rd_oth = sel_q ? p_rd_ff : q_rd_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         warm_act_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  unique case (kind_type'(req_kind))
                     KIND_LOAD: key_ff[req_word_index] <= req_word_value;
                     KIND_INIT: begin
                        win_ff   <= key_ff;
                        i_ff     <= 12'd16;
                        state_ff <= S_EXP;
                     end
                     KIND_GEN: begin
                        warm_act_ff <= 1'b0;
                        state_ff    <= S_R0;
                     end
                     default: ;
                  endcase
               end
            end
            S_EXP: begin
               win_ff[i_ff[3:0]] <= w_exp;
               i_ff <= i_ff + 12'd1;
               if (i_ff == 12'(ExpandWords - 1)) begin
                  cnt_ff      <= '0;
                  warm_ff     <= 13'(WarmupSteps);
                  warm_act_ff <= 1'b1;
                  state_ff    <= S_R0;
               end
            end
            S_R0: state_ff <= S_R1;
            S_R1: begin a_ff <= rd_own; state_ff <= S_R2; end
            S_R2: begin b_ff <= rd_own; state_ff <= S_R3; end
            S_R3: begin acc_ff <= rd_own; state_ff <= S_R4; end
            S_R4: begin acc_ff <= acc_ff + rd_own; state_ff <= S_Q0; end
            S_Q0: begin newj_ff <= newj; state_ff <= S_Q1; end
            S_Q1: begin x_ff <= rd_own; state_ff <= S_Q2; end
            S_Q2: begin sum_ff <= rd_oth; state_ff <= S_Q3; end
            S_Q3: begin sum_ff <= sum_ff + rd_oth; state_ff <= S_Q4; end
            S_Q4: begin sum_ff <= sum_ff + rd_oth; state_ff <= S_OUT; end
            S_OUT: begin
               cnt_ff <= cnt_ff + 11'd1;
               if (warm_act_ff) begin
                  warm_ff <= warm_ff - 13'd1;
                  if (warm_ff == 13'd1) begin
                     warm_act_ff <= 1'b0;
                     state_ff    <= S_IDLE;
                  end else begin
                     state_ff <= S_R0;
                  end
               end else begin
                  rsp_valid_ff <= 1'b1;
                  rsp_word_ff  <= (sum_ff + rd_oth) ^ newj_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign req_stall          = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keystream_word = rsp_word_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("item accepted while busy");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_keystream_word)))
      else $error("result dropped under stall");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |=> (cnt_ff == $past(cnt_ff) + 11'd1))
      else $error("counter did not advance");
`endif

endmodule

`default_nettype wire
